>>> sv/rau_pkg.sv
// Package for the rational arithmetic unit: payload structs, widths, operation
// codes and the microcode program that sequences the datapath.
// No dependencies; used by rational_arithmetic_unit_core.
`default_nettype none

package rau_pkg;

   // Operand width and derived internal widths.
   localparam int OPERAND_WIDTH = 16;
   // Cross products and their sum; capped at 64 bits, where sums wrap.
   localparam int INT_WIDTH = (2 * OPERAND_WIDTH + 1 > 64) ? 64 : 2 * OPERAND_WIDTH + 1;
   localparam int NUM_WIDTH = 33;
   localparam int DEN_WIDTH = 32;
   localparam int STEP_CNT_WIDTH = $clog2(INT_WIDTH);
   localparam int PC_WIDTH = 4;

   // Operation kind codes.
   localparam logic [1:0] KIND_ADD = 2'd0;
   localparam logic [1:0] KIND_SUB = 2'd1;
   localparam logic [1:0] KIND_MUL = 2'd2;
   localparam logic [1:0] KIND_DIV = 2'd3;

   // Program addresses that are jump targets or checked elsewhere.
   localparam logic [PC_WIDTH-1:0] STEP_IDLE     = 4'd0;
   localparam logic [PC_WIDTH-1:0] STEP_GCD      = 4'd6;
   localparam logic [PC_WIDTH-1:0] STEP_GCD_END  = 4'd7;
   localparam logic [PC_WIDTH-1:0] STEP_DIV_NUM  = 4'd9;
   localparam logic [PC_WIDTH-1:0] STEP_DIV_DEN  = 4'd12;
   localparam logic [PC_WIDTH-1:0] STEP_ERROR    = 4'd14;

   typedef struct packed {
      logic [1:0]                      kind;
      logic signed [OPERAND_WIDTH-1:0] lhs_num;
      logic signed [OPERAND_WIDTH-1:0] lhs_den;
      logic signed [OPERAND_WIDTH-1:0] rhs_num;
      logic signed [OPERAND_WIDTH-1:0] rhs_den;
   } req_type;

   typedef struct packed {
      logic signed [NUM_WIDTH-1:0] res_num;
      logic signed [DEN_WIDTH-1:0] res_den;
      logic                        zero_den_error;
   } rsp_type;

   // Datapath operations, one per control word.
   typedef enum logic [3:0] {
      OP_LOAD,
      OP_MUL_FIRST,
      OP_MUL_CROSS,
      OP_COMBINE,
      OP_MUL_DEN,
      OP_MAG_INIT,
      OP_GCD_STEP,
      OP_GCD_END,
      OP_DIV_INIT_NUM,
      OP_DIV_STEP,
      OP_SAVE_QUOT,
      OP_DIV_INIT_DEN,
      OP_EMIT,
      OP_EMIT_ERROR,
      OP_NOP
   } dp_op_type;

   // Jump conditions; the jump is taken when the condition holds.
   typedef enum logic [2:0] {
      COND_NEVER,
      COND_ALWAYS,
      COND_NO_START,
      COND_DEN_ZERO,
      COND_GCD_BUSY,
      COND_DIV_BUSY
   } cond_type;

   typedef struct packed {
      dp_op_type             op;
      cond_type              cond;
      logic [PC_WIDTH-1:0]   target;
   } ctrl_word_type;

   // Microcode program. Each entry is one step of the sequencer.
   function automatic ctrl_word_type ucode_rom(input logic [PC_WIDTH-1:0] pc);
      ctrl_word_type w;
      w = '{op: OP_NOP, cond: COND_ALWAYS, target: STEP_IDLE};
      case (pc)
         4'd0:  w = '{op: OP_LOAD,         cond: COND_NO_START, target: STEP_IDLE};
         4'd1:  w = '{op: OP_MUL_FIRST,    cond: COND_NEVER,    target: STEP_IDLE};
         4'd2:  w = '{op: OP_MUL_CROSS,    cond: COND_NEVER,    target: STEP_IDLE};
         4'd3:  w = '{op: OP_COMBINE,      cond: COND_NEVER,    target: STEP_IDLE};
         4'd4:  w = '{op: OP_MUL_DEN,      cond: COND_NEVER,    target: STEP_IDLE};
         4'd5:  w = '{op: OP_MAG_INIT,     cond: COND_DEN_ZERO, target: STEP_ERROR};
         4'd6:  w = '{op: OP_GCD_STEP,     cond: COND_GCD_BUSY, target: STEP_GCD};
         4'd7:  w = '{op: OP_GCD_END,      cond: COND_NEVER,    target: STEP_IDLE};
         4'd8:  w = '{op: OP_DIV_INIT_NUM, cond: COND_NEVER,    target: STEP_IDLE};
         4'd9:  w = '{op: OP_DIV_STEP,     cond: COND_DIV_BUSY, target: STEP_DIV_NUM};
         4'd10: w = '{op: OP_SAVE_QUOT,    cond: COND_NEVER,    target: STEP_IDLE};
         4'd11: w = '{op: OP_DIV_INIT_DEN, cond: COND_NEVER,    target: STEP_IDLE};
         4'd12: w = '{op: OP_DIV_STEP,     cond: COND_DIV_BUSY, target: STEP_DIV_DEN};
         4'd13: w = '{op: OP_EMIT,         cond: COND_ALWAYS,   target: STEP_IDLE};
         4'd14: w = '{op: OP_EMIT_ERROR,   cond: COND_ALWAYS,   target: STEP_IDLE};
         default: w = '{op: OP_NOP,        cond: COND_ALWAYS,   target: STEP_IDLE};
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

>>> sv/rational_arithmetic_unit_core.sv
// Rational arithmetic unit top level: microcoded datapath for fraction
// add, subtract, multiply and divide with reduction to lowest terms.
// Depends on rau_pkg (types, widths, microcode program).
`default_nettype none

// A beat is accepted when start is high while busy is low; busy then stays
// high until the result is out. Each item runs through the setup steps
// (load, three products on one shared multiplier, the sum, zero check), then
// the binary GCD loop at one shift or subtract per cycle, then two restoring
// divisions by the GCD, each over all INT_WIDTH bits of its dividend
// (INT_WIDTH being 33 for 16-bit operands), with bookkeeping around them
// (forming the GCD, loading each dividend, saving the first quotient), and
// the emit step. A zero denominator skips the GCD and divisions and goes
// from the zero check straight to the error result. The result beat is shown
// for exactly one cycle on rsp_valid and cannot be held off; the next start
// may be taken in that same cycle.
module rational_arithmetic_unit_core (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            start,
   output logic                 busy,
   input  wire rau_pkg::req_type req_data,
   output logic                 rsp_valid,
   output rau_pkg::rsp_type     rsp_data
);

   localparam int W   = rau_pkg::OPERAND_WIDTH;
   localparam int IW  = rau_pkg::INT_WIDTH;
   localparam int CW  = rau_pkg::STEP_CNT_WIDTH;
   localparam int NXW = (IW > rau_pkg::NUM_WIDTH) ? IW : rau_pkg::NUM_WIDTH;
   localparam int DXW = (IW > rau_pkg::DEN_WIDTH) ? IW : rau_pkg::DEN_WIDTH;

   // Sequencer state.
   logic [rau_pkg::PC_WIDTH-1:0] pc_ff, pc_in;
   rau_pkg::ctrl_word_type       cw;
   logic                         jump;
   logic                         accept;

   // Datapath registers.
   rau_pkg::req_type      req_ff, req_in;
   logic signed [IW-1:0]  t_ff, t_in;
   logic signed [IW-1:0]  p_ff, p_in;
   logic signed [IW-1:0]  n_ff, n_in;
   logic signed [IW-1:0]  m_ff, m_in;
   logic [IW-1:0]         u_ff, u_in;
   logic [IW-1:0]         v_ff, v_in;
   logic [CW-1:0]         k_ff, k_in;
   logic [IW-1:0]         g_ff, g_in;
   logic [IW-1:0]         dq_ff, dq_in;
   logic [IW-1:0]         rem_ff, rem_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic [IW-1:0]         qn_ff, qn_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rau_pkg::rsp_type      rsp_ff, rsp_in;

   // Combinational helpers.
   logic signed [W-1:0]   mul_x, mul_y;
   logic signed [2*W-1:0] mul_out;
   logic signed [IW-1:0]  mul_ext;
   logic [IW-1:0]         mag_n, mag_m;
   logic [IW:0]           diff_uv;
   logic [IW-1:0]         diff_vu;
   logic [IW-1:0]         rem_sh;
   logic [IW:0]           trial;
   logic [NXW-1:0]        num_ext, num_sgn;
   logic [DXW-1:0]        den_ext, den_sgn;

   // Fetch the control word and decide the next step.
   assign cw     = rau_pkg::ucode_rom(pc_ff);
   assign busy   = (pc_ff != rau_pkg::STEP_IDLE);
   assign accept = start && !busy;

   always_comb begin
      case (cw.cond)
         rau_pkg::COND_NEVER:    jump = 1'b0;
         rau_pkg::COND_ALWAYS:   jump = 1'b1;
         rau_pkg::COND_NO_START: jump = !start;
         rau_pkg::COND_DEN_ZERO: jump = (m_ff == '0);
         rau_pkg::COND_GCD_BUSY: jump = (v_ff != '0);
         rau_pkg::COND_DIV_BUSY: jump = (cnt_ff != CW'(IW - 1));
         default:                jump = 1'b0;
      endcase
      pc_in = jump ? cw.target : pc_ff + 1'b1;
   end

   // Shared multiplier; operand choice follows the step and the kind.
   always_comb begin
      mul_x = req_ff.lhs_num;
      mul_y = req_ff.rhs_den;
      case (cw.op)
         rau_pkg::OP_MUL_FIRST: begin
            mul_x = req_ff.lhs_num;
            mul_y = (req_ff.kind == rau_pkg::KIND_MUL) ? req_ff.rhs_num : req_ff.rhs_den;
         end
         rau_pkg::OP_MUL_CROSS: begin
            mul_x = req_ff.rhs_num;
            mul_y = req_ff.lhs_den;
         end
         rau_pkg::OP_MUL_DEN: begin
            mul_x = req_ff.lhs_den;
            mul_y = (req_ff.kind == rau_pkg::KIND_DIV) ? req_ff.rhs_num : req_ff.rhs_den;
         end
         default: begin
            mul_x = req_ff.lhs_num;
            mul_y = req_ff.rhs_den;
         end
      endcase
   end

   assign mul_out = mul_x * mul_y;
   assign mul_ext = IW'(mul_out);

   // Magnitudes of the unreduced parts; the most negative value maps to 2^(IW-1).
   assign mag_n = n_ff[IW-1] ? unsigned'(-n_ff) : unsigned'(n_ff);
   assign mag_m = m_ff[IW-1] ? unsigned'(-m_ff) : unsigned'(m_ff);

   // GCD compare and subtract.
   assign diff_uv = {1'b0, u_ff} - {1'b0, v_ff};
   assign diff_vu = v_ff - u_ff;

   // Restoring division: shift in the next dividend bit and try the subtract.
   assign rem_sh = {rem_ff[IW-2:0], dq_ff[IW-1]};
   assign trial  = {1'b0, rem_sh} - {1'b0, g_ff};

   // Reapply the signs to the quotients and fit them to the result fields.
   assign num_ext = NXW'(qn_ff);
   assign num_sgn = n_ff[IW-1] ? NXW'(0) - num_ext : num_ext;
   assign den_ext = DXW'(dq_ff);
   assign den_sgn = m_ff[IW-1] ? DXW'(0) - den_ext : den_ext;

   // Datapath next-state logic, one operation per control word.
   always_comb begin
      req_in       = req_ff;
      t_in         = t_ff;
      p_in         = p_ff;
      n_in         = n_ff;
      m_in         = m_ff;
      u_in         = u_ff;
      v_in         = v_ff;
      k_in         = k_ff;
      g_in         = g_ff;
      dq_in        = dq_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      qn_in        = qn_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      case (cw.op)
         rau_pkg::OP_LOAD: begin
            if (accept) begin
               req_in = req_data;
            end
         end
         rau_pkg::OP_MUL_FIRST: t_in = mul_ext;
         rau_pkg::OP_MUL_CROSS: p_in = mul_ext;
         rau_pkg::OP_COMBINE: begin
            case (req_ff.kind)
               rau_pkg::KIND_ADD: n_in = t_ff + p_ff;
               rau_pkg::KIND_SUB: n_in = t_ff - p_ff;
               default:           n_in = t_ff;
            endcase
         end
         rau_pkg::OP_MUL_DEN: m_in = mul_ext;
         rau_pkg::OP_MAG_INIT: begin
            u_in = mag_n;
            v_in = mag_m;
            k_in = '0;
         end
         rau_pkg::OP_GCD_STEP: begin
            // Binary GCD; ends with v at zero and u holding the GCD divided by 2^k.
            if (v_ff == '0) begin
               u_in = u_ff;
            end else if (u_ff == '0) begin
               u_in = v_ff;
               v_in = '0;
            end else if (!u_ff[0] && !v_ff[0]) begin
               u_in = u_ff >> 1;
               v_in = v_ff >> 1;
               k_in = k_ff + 1'b1;
            end else if (!u_ff[0]) begin
               u_in = u_ff >> 1;
            end else if (!v_ff[0]) begin
               v_in = v_ff >> 1;
            end else if (!diff_uv[IW]) begin
               u_in = diff_uv[IW-1:0];
            end else begin
               v_in = diff_vu;
            end
         end
         rau_pkg::OP_GCD_END: g_in = u_ff << k_ff;
         rau_pkg::OP_DIV_INIT_NUM: begin
            dq_in  = mag_n;
            rem_in = '0;
            cnt_in = '0;
         end
         rau_pkg::OP_DIV_INIT_DEN: begin
            dq_in  = mag_m;
            rem_in = '0;
            cnt_in = '0;
         end
         rau_pkg::OP_DIV_STEP: begin
            rem_in = trial[IW] ? rem_sh : trial[IW-1:0];
            dq_in  = {dq_ff[IW-2:0], !trial[IW]};
            cnt_in = cnt_ff + 1'b1;
         end
         rau_pkg::OP_SAVE_QUOT: qn_in = dq_ff;
         rau_pkg::OP_EMIT: begin
            rsp_valid_in          = 1'b1;
            rsp_in.res_num        = num_sgn[rau_pkg::NUM_WIDTH-1:0];
            rsp_in.res_den        = den_sgn[rau_pkg::DEN_WIDTH-1:0];
            rsp_in.zero_den_error = 1'b0;
         end
         rau_pkg::OP_EMIT_ERROR: begin
            rsp_valid_in          = 1'b1;
            rsp_in.res_num        = '0;
            rsp_in.res_den        = '0;
            rsp_in.zero_den_error = 1'b1;
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= rau_pkg::STEP_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      req_ff <= req_in;
      t_ff   <= t_in;
      p_ff   <= p_in;
      n_ff   <= n_in;
      m_ff   <= m_in;
      u_ff   <= u_in;
      v_ff   <= v_in;
      k_ff   <= k_in;
      g_ff   <= g_in;
      dq_ff  <= dq_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      qn_ff  <= qn_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // An accepted beat makes the unit busy in the next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("unit not busy after accepting a beat");

   // A result is strobed for one cycle only.
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   // An error result carries 0/0.
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.zero_den_error) |->
         (rsp_data.res_num == '0 && rsp_data.res_den == '0))
      else $error("error result with nonzero parts");

   // The GCD of a nonzero denominator is never zero.
   a_gcd_nonzero: assert property (@(posedge clock) disable iff (reset)
      (pc_ff == rau_pkg::STEP_GCD_END) |-> (u_ff != '0))
      else $error("GCD finished at zero");

   // The partial remainder stays below the divisor throughout a division.
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (pc_ff == rau_pkg::STEP_DIV_NUM || pc_ff == rau_pkg::STEP_DIV_DEN) |->
         (rem_ff < g_ff))
      else $error("division remainder not below divisor");

endmodule

`default_nettype wire
